>>> rtl/idiv_pkg.sv
// Package for the pipelined integer divider: widths, defaults and stage control types.
package idiv_pkg;

    // Fixed width of the dividend, divisor and quotient fields on the ports.
    localparam int unsigned FIELD_W = 64;

    // Default operand width; legal range 8 to FIELD_W.
    localparam int unsigned DATA_WIDTH_DEF = 64;

    // Encoding of the op bit.
    localparam logic OP_SIGNED   = 1'b0;
    localparam logic OP_UNSIGNED = 1'b1;

    // Control that travels down the pipeline with each word.
    typedef struct packed {
        logic valid;     // stage holds a word
        logic negate;    // operand signs differ under signed division
        logic zero_div;  // divisor was zero, quotient forced to 0
    } t_stage_ctl;

endpackage

>>> rtl/idiv_if.sv
// Valid/ready channel interfaces for divider operands and quotients.
interface idiv_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic [idiv_pkg::FIELD_W-1:0]      dividend;
    logic [idiv_pkg::FIELD_W-1:0]      divisor;

    modport source (output valid, output op, output dividend, output divisor, input ready);
    modport sink   (input valid, input op, input dividend, input divisor, output ready);
endinterface

interface idiv_out_if;
    logic                              valid;
    logic                              ready;
    logic [idiv_pkg::FIELD_W-1:0]      quotient;

    modport source (output valid, output quotient, input ready);
    modport sink   (input valid, input quotient, output ready);
endinterface

>>> rtl/integer_divider_64.sv
// Top level of the pipelined signed/unsigned integer divider.
// integer_divider_64 returns the truncating quotient of dividend / divisor, one word per
// operation; op = 0 treats both operands as two's complement, op = 1 as unsigned. Only
// the low DATA_WIDTH bits of each operand are used and the quotient is zero-extended to
// 64 bits. A zero divisor gives a quotient of 0; the most negative value divided by -1
// wraps to the most negative value. No remainder is returned. Throughput is one word per
// clock while the output is not stalled: the restoring division is unrolled into
// DATA_WIDTH stages, each doing one trial subtract of DATA_WIDTH+1 bits, so a new
// operation can enter every cycle. The pipeline has one conditioning stage for
// magnitudes, DATA_WIDTH division stages, and one stage for sign correction and the
// output register. Every stage stalls on its own, so an empty stage still accepts a word
// while the output waits, and no word is lost or repeated under back-pressure.
module integer_divider_64 #(
    parameter int unsigned DATA_WIDTH = idiv_pkg::DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    idiv_in_if.sink      i_in,
    idiv_out_if.source   o_out
);

    // Stage k feeds division step k; index DATA_WIDTH feeds the output stage.
    idiv_pkg::t_stage_ctl  s_ctl [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_rem [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_den [0:DATA_WIDTH];
    logic [DATA_WIDTH-1:0] s_nq  [0:DATA_WIDTH];
    // s_rdy[k]: the consumer of stage k can take a word
    logic                  s_rdy [0:DATA_WIDTH];

    // Partial remainder starts at zero.
    assign s_rem[0] = '0;

    idiv_pre #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (s_rdy[0]),
        .o_ctl   (s_ctl[0]),
        .o_num   (s_nq[0]),
        .o_den   (s_den[0])
    );

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
        idiv_step #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[k]),
            .i_rem   (s_rem[k]),
            .i_den   (s_den[k]),
            .i_nq    (s_nq[k]),
            .o_ready (s_rdy[k]),
            .i_ready (s_rdy[k+1]),
            .o_ctl   (s_ctl[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_den   (s_den[k+1]),
            .o_nq    (s_nq[k+1])
        );
    end

    idiv_post #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl[DATA_WIDTH]),
        .i_quo   (s_nq[DATA_WIDTH]),
        .o_ready (s_rdy[DATA_WIDTH]),
        .o_out   (o_out)
    );

    // Final remainder and divisor copy are not needed past the last step.
    logic unused_tail;
    assign unused_tail = ^{s_rem[DATA_WIDTH], s_den[DATA_WIDTH]};

endmodule

>>> rtl/idiv_pre.sv
// Operand conditioning stage: width trim, magnitudes, sign and zero-divisor flags.
module idiv_pre #(
    parameter int unsigned DATA_WIDTH = idiv_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    idiv_in_if.sink                    i_in,
    input  logic                       i_ready,
    output idiv_pkg::t_stage_ctl       o_ctl,
    output logic [DATA_WIDTH-1:0]      o_num,
    output logic [DATA_WIDTH-1:0]      o_den
);

    idiv_pkg::t_stage_ctl  r_ctl, n_ctl;
    logic [DATA_WIDTH-1:0] r_num, n_num;
    logic [DATA_WIDTH-1:0] r_den, n_den;
    logic                  load;

    logic [DATA_WIDTH-1:0] a, b;
    logic                  is_signed, neg_a, neg_b;

    assign load       = !r_ctl.valid || i_ready;
    assign i_in.ready = load;

    always_comb begin
        a         = i_in.dividend[DATA_WIDTH-1:0];
        b         = i_in.divisor[DATA_WIDTH-1:0];
        is_signed = (i_in.op == idiv_pkg::OP_SIGNED);
        neg_a     = is_signed && a[DATA_WIDTH-1];
        neg_b     = is_signed && b[DATA_WIDTH-1];
        n_num     = neg_a ? (~a + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : a;
        n_den     = neg_b ? (~b + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : b;
        n_ctl.valid    = i_in.valid;
        n_ctl.negate   = neg_a ^ neg_b;
        n_ctl.zero_div = (b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (load) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    assign o_ctl = r_ctl;
    assign o_num = r_num;
    assign o_den = r_den;

endmodule

>>> rtl/idiv_step.sv
// One restoring division step: shift in a dividend bit, trial subtract, record quotient bit.
module idiv_step #(
    parameter int unsigned DATA_WIDTH = idiv_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  idiv_pkg::t_stage_ctl       i_ctl,
    input  logic [DATA_WIDTH-1:0]      i_rem,
    input  logic [DATA_WIDTH-1:0]      i_den,
    input  logic [DATA_WIDTH-1:0]      i_nq,
    output logic                       o_ready,
    input  logic                       i_ready,
    output idiv_pkg::t_stage_ctl       o_ctl,
    output logic [DATA_WIDTH-1:0]      o_rem,
    output logic [DATA_WIDTH-1:0]      o_den,
    output logic [DATA_WIDTH-1:0]      o_nq
);

    // nq holds the unconsumed dividend bits at the top and the quotient bits at the bottom.
    idiv_pkg::t_stage_ctl  r_ctl;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_den;
    logic [DATA_WIDTH-1:0] r_nq, n_nq;
    logic [DATA_WIDTH:0]   shifted, diff;
    logic                  load;

    assign load    = !r_ctl.valid || i_ready;
    assign o_ready = load;

    always_comb begin
        shifted = {i_rem, i_nq[DATA_WIDTH-1]};
        diff    = shifted - {1'b0, i_den};
        // no borrow: remainder fits, quotient bit is one
        if (!diff[DATA_WIDTH]) begin
            n_rem = diff[DATA_WIDTH-1:0];
            n_nq  = {i_nq[DATA_WIDTH-2:0], 1'b1};
        end else begin
            n_rem = shifted[DATA_WIDTH-1:0];
            n_nq  = {i_nq[DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (load) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_nq  <= n_nq;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_nq  = r_nq;

endmodule

>>> rtl/idiv_post.sv
// Output stage: zero-divisor override, sign correction and the quotient output register.
module idiv_post #(
    parameter int unsigned DATA_WIDTH = idiv_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  idiv_pkg::t_stage_ctl       i_ctl,
    input  logic [DATA_WIDTH-1:0]      i_quo,
    output logic                       o_ready,
    idiv_out_if.source                 o_out
);

    logic                             r_valid;
    logic [idiv_pkg::FIELD_W-1:0]     r_quotient, n_quotient;
    logic [DATA_WIDTH-1:0]            q;
    logic                             load;

    assign load    = !r_valid || o_out.ready;
    assign o_ready = load;

    always_comb begin
        if (i_ctl.zero_div) begin
            q = '0;
        end else if (i_ctl.negate) begin
            q = ~i_quo + {{(DATA_WIDTH-1){1'b0}}, 1'b1};
        end else begin
            q = i_quo;
        end
        // zero above the operand width
        n_quotient                 = '0;
        n_quotient[DATA_WIDTH-1:0] = q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_quotient <= n_quotient;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.quotient = r_quotient;

endmodule
